/* sv/pgwalk_pkg.sv */
`default_nettype none

package pgwalk_pkg;

  // Width of physical addresses kept by the walker (32 to 52).
  localparam int PHYS_ADDR_BITS = 52;
  localparam int ADDR_W         = 52;
  localparam logic [ADDR_W-1:0] PHYS_MASK = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the request channel.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_MEM_RSP   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_READ        = 2'd0;
  localparam logic [1:0] KIND_WRITE_ZERO  = 2'd1;
  localparam logic [1:0] KIND_TRANSL_DONE = 2'd2;
  localparam logic [1:0] KIND_UNMAP_DONE  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_ARGS    = 3'd1;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [2:0] ST_LARGE_PAGE  = 3'd3;
  localparam logic [2:0] ST_BUSY        = 3'd4;

  // Configuration register indexes.
  localparam logic REG_MMIO_FLAG_BIT = 1'b0;
  localparam logic [5:0] MMIO_FLAG_BIT_RESET = 6'd9;

  // Entry bits.
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  // One queued record. When two is set, the record stands for a write-zero
  // to mem_address followed by an unmap done result carrying phys_addr.
  typedef struct packed {
    logic [1:0]        kind;
    logic              two;
    logic [ADDR_W-1:0] mem_address;
    logic [ADDR_W-1:0] phys_addr;
    logic              is_mmio;
    logic [2:0]        status;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Nine-bit table index of a virtual address for a level (3 = top table).
  function automatic logic [8:0] level_index(input logic [63:0] virt, input logic [1:0] level);
    logic [8:0] idx;
    case (level)
      2'd0:    idx = virt[20:12];
      2'd1:    idx = virt[29:21];
      2'd2:    idx = virt[38:30];
      2'd3:    idx = virt[47:39];
      default: idx = virt[47:39];
    endcase
    return idx;
  endfunction

  // Table base plus eight times the index, wrapped to the address width.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [8:0] idx);
    logic [ADDR_W-1:0] sum;
    sum = base + {{(ADDR_W-12){1'b0}}, idx, 3'b000};
    return sum & PHYS_MASK;
  endfunction

endpackage

`default_nettype wire

/* sv/pgwalk_if.sv */
`default_nettype none

interface pgwalk_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [51:0] root_table;
  logic [63:0] virt_addr;
  logic [63:0] entry_data;

  modport source (output valid, operation, root_table, virt_addr, entry_data, input ready);
  modport sink   (input valid, operation, root_table, virt_addr, entry_data, output ready);
endinterface

interface pgwalk_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [51:0] mem_address;
  logic [51:0] phys_addr;
  logic        is_mmio;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, mem_address, phys_addr, is_mmio, status, last,
                  input ready);
  modport sink   (input valid, kind, mem_address, phys_addr, is_mmio, status, last,
                  output ready);
endinterface

`default_nettype wire

/* sv/pgwalk_front.sv */
`default_nettype none

module pgwalk_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  pgwalk_req_if.sink                req_i,
  input  wire logic                 full_i,
  input  wire logic [5:0]           mmio_flag_bit_i,
  output pgwalk_pkg::push_t         push_o
);

  logic        busy_q, busy_d;
  logic        unmap_q, unmap_d;
  logic [1:0]  level_q, level_d;
  logic [63:0] virt_q, virt_d;
  logic [pgwalk_pkg::ADDR_W-1:0] leaf_q, leaf_d;

  logic        accept;
  logic        is_req;
  logic        req_unmap;
  logic        bad;
  logic [1:0]  done_kind;
  logic [1:0]  next_level;
  logic [pgwalk_pkg::ADDR_W-1:0] frame;
  logic        mmio;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && req_i.ready;

  assign is_req    = (req_i.operation == pgwalk_pkg::OP_TRANSLATE) ||
                     (req_i.operation == pgwalk_pkg::OP_UNMAP);
  assign req_unmap = (req_i.operation == pgwalk_pkg::OP_UNMAP);
  assign bad       = (req_i.root_table == '0) ||
                     (req_unmap ? (|req_i.virt_addr[11:0]) : (|req_i.virt_addr[63:47]));
  assign done_kind = unmap_q ? pgwalk_pkg::KIND_UNMAP_DONE : pgwalk_pkg::KIND_TRANSL_DONE;
  assign next_level = level_q - 2'd1;
  assign frame     = {req_i.entry_data[51:12], 12'h000} & pgwalk_pkg::PHYS_MASK;
  assign mmio      = req_i.entry_data[mmio_flag_bit_i];

  always_comb begin
    busy_d  = busy_q;
    unmap_d = unmap_q;
    level_d = level_q;
    virt_d  = virt_q;
    leaf_d  = leaf_q;
    push_o  = '0;

    if (accept && is_req) begin
      push_o.valid       = 1'b1;
      push_o.entry.kind  = req_unmap ? pgwalk_pkg::KIND_UNMAP_DONE
                                     : pgwalk_pkg::KIND_TRANSL_DONE;
      if (busy_q) begin
        push_o.entry.status = pgwalk_pkg::ST_BUSY;
      end else if (bad) begin
        push_o.entry.status = pgwalk_pkg::ST_BAD_ARGS;
      end else begin
        busy_d  = 1'b1;
        unmap_d = req_unmap;
        level_d = 2'd3;
        virt_d  = req_i.virt_addr;
        leaf_d  = pgwalk_pkg::entry_addr(req_i.root_table,
                                         pgwalk_pkg::level_index(req_i.virt_addr, 2'd3));
        push_o.entry.kind        = pgwalk_pkg::KIND_READ;
        push_o.entry.mem_address = leaf_d;
      end
    end else if (accept && (req_i.operation == pgwalk_pkg::OP_MEM_RSP) && busy_q) begin
      push_o.valid = 1'b1;
      if (!req_i.entry_data[pgwalk_pkg::PRESENT_BIT]) begin
        busy_d              = 1'b0;
        push_o.entry.kind   = done_kind;
        push_o.entry.status = pgwalk_pkg::ST_NOT_PRESENT;
      end else if ((level_q == 2'd1) && req_i.entry_data[pgwalk_pkg::LARGE_BIT]) begin
        busy_d              = 1'b0;
        push_o.entry.kind   = done_kind;
        push_o.entry.status = pgwalk_pkg::ST_LARGE_PAGE;
      end else if (level_q != 2'd0) begin
        level_d = next_level;
        leaf_d  = pgwalk_pkg::entry_addr(frame, pgwalk_pkg::level_index(virt_q, next_level));
        push_o.entry.kind        = pgwalk_pkg::KIND_READ;
        push_o.entry.mem_address = leaf_d;
      end else begin
        busy_d               = 1'b0;
        push_o.entry.is_mmio = mmio;
        if (unmap_q) begin
          push_o.entry.kind        = pgwalk_pkg::KIND_UNMAP_DONE;
          push_o.entry.two         = 1'b1;
          push_o.entry.mem_address = leaf_q;
          push_o.entry.phys_addr   = frame;
        end else begin
          push_o.entry.kind      = pgwalk_pkg::KIND_TRANSL_DONE;
          push_o.entry.phys_addr = (frame + {{(pgwalk_pkg::ADDR_W-12){1'b0}},
                                             virt_q[11:0]}) & pgwalk_pkg::PHYS_MASK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      unmap_q <= 1'b0;
      level_q <= 2'd0;
      virt_q  <= '0;
      leaf_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      unmap_q <= unmap_d;
      level_q <= level_d;
      virt_q  <= virt_d;
      leaf_q  <= leaf_d;
    end
  end

endmodule

`default_nettype wire

/* sv/pgwalk_queue.sv */
`default_nettype none

module pgwalk_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pgwalk_pkg::push_t   push_i,
  output logic                     full_o,
  output pgwalk_pkg::head_t        head_o,
  input  wire logic                pop_i
);

  pgwalk_pkg::entry_t slots_q [pgwalk_pkg::QUEUE_DEPTH];

  logic [pgwalk_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pgwalk_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pgwalk_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic do_pop;

  assign full_o       = (count_q == pgwalk_pkg::QUEUE_CNT_W'(pgwalk_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slots_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + pgwalk_pkg::QUEUE_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + pgwalk_pkg::QUEUE_PTR_W'(1);
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + pgwalk_pkg::QUEUE_CNT_W'(1);
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - pgwalk_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slots_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

/* sv/pgwalk_back.sv */
`default_nettype none

module pgwalk_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pgwalk_pkg::head_t   head_i,
  output logic                     pop_o,
  pgwalk_rsp_if.source             rsp_o
);

  // Set once the write-zero half of a two-result record has gone out.
  logic second_q, second_d;
  logic xfer;
  logic first_half;

  assign xfer       = rsp_o.valid && rsp_o.ready;
  assign first_half = head_i.entry.two && !second_q;
  assign pop_o      = xfer && !first_half;

  assign rsp_o.valid = head_i.valid;

  always_comb begin
    if (first_half) begin
      rsp_o.kind        = pgwalk_pkg::KIND_WRITE_ZERO;
      rsp_o.mem_address = head_i.entry.mem_address;
      rsp_o.phys_addr   = '0;
      rsp_o.is_mmio     = 1'b0;
      rsp_o.status      = pgwalk_pkg::ST_OK;
      rsp_o.last        = 1'b0;
    end else begin
      rsp_o.kind        = head_i.entry.kind;
      rsp_o.mem_address = head_i.entry.two ? '0 : head_i.entry.mem_address;
      rsp_o.phys_addr   = head_i.entry.phys_addr;
      rsp_o.is_mmio     = head_i.entry.is_mmio;
      rsp_o.status      = head_i.entry.status;
      rsp_o.last        = 1'b1;
    end
  end

  always_comb begin
    second_d = second_q;
    if (xfer) begin
      second_d = first_half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

/* sv/four_level_page_table_walker.sv */
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    operation, root_table, virt_addr, entry_data
// rsp_o     out  valid/ready    kind, mem_address, phys_addr, is_mmio, status, last
// APB       in   psel/penable   paddr, pwrite, pwdata, prdata, pready (always high)
//
// Every request and memory response is handled in the cycle it is taken: the
// front end updates the walk state and writes at most one record into a
// four-entry queue, so one item per cycle is sustained. The output side sends
// one transfer per cycle while rsp_o.ready is high; an unmap's leaf response
// gives two (write-zero, then unmap done). Requests stall only while the queue
// is full. Reset clears the walk state and the queue and sets mmio_flag_bit to 9.

module four_level_page_table_walker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pgwalk_req_if.sink       req_i,
  pgwalk_rsp_if.source     rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pgwalk_pkg::push_t push;
  pgwalk_pkg::head_t head;
  logic              full;
  logic              pop;

  // The configuration register selecting which leaf entry bit marks MMIO.
  logic [5:0] mmio_flag_bit_q, mmio_flag_bit_d;
  logic       reg_write;

  // Registers sit at word addresses, so bit 2 of paddr picks the register.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == pgwalk_pkg::REG_MMIO_FLAG_BIT);
  assign prdata    = (paddr[2] == pgwalk_pkg::REG_MMIO_FLAG_BIT) ?
                     {26'd0, mmio_flag_bit_q} : 32'd0;

  always_comb begin
    mmio_flag_bit_d = mmio_flag_bit_q;
    if (reg_write) begin
      mmio_flag_bit_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mmio_flag_bit_q <= pgwalk_pkg::MMIO_FLAG_BIT_RESET;
    end else begin
      mmio_flag_bit_q <= mmio_flag_bit_d;
    end
  end

  // Front end: takes requests and responses, keeps the walk state.
  pgwalk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .full_i          (full),
    .mmio_flag_bit_i (mmio_flag_bit_q),
    .push_o          (push)
  );

  // Queue of result records between the two halves.
  pgwalk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back end: turns each record into one or two result transfers.
  pgwalk_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwalk_pkg::*;

  // Operation code 3 is unused; the walker must ignore it.
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  // Highest virtual address a translate may ask for.
  localparam logic [63:0] USER_TOP      = 64'h0000_7FFF_FFFF_FFFF;
  // The only register, mmio_flag_bit, sits at byte address zero.
  localparam logic [2:0]  FLAG_REG_ADDR = {REG_MMIO_FLAG_BIT, 2'b00};
  // Cycles allowed after the last result for items that cause none.
  localparam int          DRAIN_CYCLES  = 16;
  // Length of the one long receiver stall.
  localparam int          HOLD_CYCLES   = 300;

  // One item on the request channel.
  typedef struct packed {
    logic [1:0]  operation;
    logic [51:0] root_table;
    logic [63:0] virt_addr;
    logic [63:0] entry_data;
  } walk_item_t;

  // One result on the response channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [51:0] mem_address;
    logic [51:0] phys_addr;
    logic        is_mmio;
    logic [2:0]  status;
    logic        last;
  } walk_answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pgwalk_req_if req_if ();
  pgwalk_rsp_if rsp_if ();

  four_level_page_table_walker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting for the driver, and the results the walker still owes.
  walk_item_t   pending_items[$];
  walk_answer_t walker_answers[$];
  walk_item_t   req_offer;
  int           items_queued   = 0;
  int           items_accepted = 0;
  int           mismatches     = 0;

  // Idle rates in percent for both sides, and the long receiver stall.
  int unsigned  send_idle_pct = 8;
  int unsigned  rsp_idle_pct  = 71;
  logic         hold_go       = 1'b0;
  logic         rsp_hold      = 1'b0;

  // Our own copy of the walker state and its configuration.
  logic         walking       = 1'b0;
  logic         walk_unmap    = 1'b0;
  logic [1:0]   walk_lvl      = 2'd0;
  logic [63:0]  walk_va       = '0;
  logic [51:0]  entry_ptr     = '0;
  logic [5:0]   mmio_flag_pos = MMIO_FLAG_BIT_RESET;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void owe_answer(logic [1:0] kind, logic [51:0] mem_address,
                                     logic [51:0] phys_addr, logic is_mmio,
                                     logic [2:0] status, logic last);
    walker_answers.push_back('{kind, mem_address, phys_addr, is_mmio, status, last});
  endfunction

  // Address of the entry that a virtual address selects in a table at one level.
  // The sum wraps within the physical address width.
  function automatic logic [51:0] table_slot(logic [51:0] base, logic [63:0] va,
                                             logic [1:0] lvl);
    logic [8:0] idx;
    idx = 9'(va >> (12 + 9 * int'(lvl)));
    return (base + {40'd0, idx, 3'b000}) & PHYS_MASK;
  endfunction

  // Moves our copy of the walker by one accepted item and records the results
  // that the item must cause, in order.
  function automatic void advance_walk(walk_item_t it);
    logic [1:0]  done_kind;
    logic [51:0] frame;
    logic        mmio;
    done_kind = walk_unmap ? KIND_UNMAP_DONE : KIND_TRANSL_DONE;
    frame     = {it.entry_data[51:12], 12'h000} & PHYS_MASK;
    mmio      = it.entry_data[mmio_flag_pos];
    case (it.operation)
      OP_TRANSLATE, OP_UNMAP: begin
        done_kind = (it.operation == OP_UNMAP) ? KIND_UNMAP_DONE : KIND_TRANSL_DONE;
        if (walking) begin
          // A second request never disturbs the walk in progress.
          owe_answer(done_kind, '0, '0, 1'b0, ST_BUSY, 1'b1);
        end else if (it.root_table == '0 ||
                     (it.operation == OP_UNMAP ? it.virt_addr[11:0] != 12'h000
                                               : it.virt_addr > USER_TOP)) begin
          owe_answer(done_kind, '0, '0, 1'b0, ST_BAD_ARGS, 1'b1);
        end else begin
          walking    = 1'b1;
          walk_unmap = (it.operation == OP_UNMAP);
          walk_lvl   = 2'd3;
          walk_va    = it.virt_addr;
          entry_ptr  = table_slot(it.root_table & PHYS_MASK, it.virt_addr, 2'd3);
          owe_answer(KIND_READ, entry_ptr, '0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_MEM_RSP: begin
        // A memory response with no walk in progress is dropped.
        if (walking) begin
          if (!it.entry_data[PRESENT_BIT]) begin
            walking = 1'b0;
            owe_answer(done_kind, '0, '0, 1'b0, ST_NOT_PRESENT, 1'b1);
          end else if (walk_lvl == 2'd1 && it.entry_data[LARGE_BIT]) begin
            // Only the level-two entry is checked for a large page.
            walking = 1'b0;
            owe_answer(done_kind, '0, '0, 1'b0, ST_LARGE_PAGE, 1'b1);
          end else if (walk_lvl != 2'd0) begin
            walk_lvl  = walk_lvl - 2'd1;
            entry_ptr = table_slot(frame, walk_va, walk_lvl);
            owe_answer(KIND_READ, entry_ptr, '0, 1'b0, ST_OK, 1'b1);
          end else begin
            walking = 1'b0;
            if (walk_unmap) begin
              owe_answer(KIND_WRITE_ZERO, entry_ptr, '0, 1'b0, ST_OK, 1'b0);
              owe_answer(KIND_UNMAP_DONE, '0, frame, mmio, ST_OK, 1'b1);
            end else begin
              owe_answer(KIND_TRANSL_DONE, '0,
                         (frame + {40'd0, walk_va[11:0]}) & PHYS_MASK, mmio, ST_OK, 1'b1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Driver. The expected results of an item are worked out at the edge where
  // its transfer happens; a new item is offered whenever the channel is free,
  // unless the sender decides to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        advance_walk(req_offer);
        items_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_offer             = pending_items.pop_front();
          req_if.valid         <= 1'b1;
          req_if.operation     <= req_offer.operation;
          req_if.root_table    <= req_offer.root_table;
          req_if.virt_addr     <= req_offer.virt_addr;
          req_if.entry_data    <= req_offer.entry_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result transfer is held against the oldest result still
  // owed; ready is redrawn every cycle, and forced low during the long stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (walker_answers.size() == 0) begin
          $error("result with nothing owed: kind %0d mem_address %0h phys_addr %0h status %0d",
                 rsp_if.kind, rsp_if.mem_address, rsp_if.phys_addr, rsp_if.status);
          mismatches++;
        end else begin
          walk_answer_t want;
          want = walker_answers.pop_front();
          check_field("kind", 64'(want.kind), 64'(rsp_if.kind));
          check_field("mem_address", 64'(want.mem_address), 64'(rsp_if.mem_address));
          check_field("phys_addr", 64'(want.phys_addr), 64'(rsp_if.phys_addr));
          check_field("is_mmio", 64'(want.is_mmio), 64'(rsp_if.is_mmio));
          check_field("status", 64'(want.status), 64'(rsp_if.status));
          check_field("last", 64'(want.last), 64'(rsp_if.last));
        end
      end
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // The long receiver stall runs in its own process once the stimulus asks
  // for it. The sender keeps offering items meanwhile, so the walker's output
  // queue fills and the request channel backs up.
  initial begin : rsp_hold_off
    wait (hold_go);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  function automatic void queue_item(logic [1:0] op, logic [51:0] root,
                                     logic [63:0] virt, logic [63:0] entry);
    pending_items.push_back('{op, root, virt, entry});
    items_queued++;
  endfunction

  // A well-formed walk: a request with valid arguments, then one memory
  // response per level. Entries are mostly present, the level-two entry is
  // sometimes a large page, and now and then a second request arrives while
  // the walk is in progress.
  task automatic queue_walk();
    logic        unmap;
    logic [51:0] root;
    logic [63:0] virt;
    logic [63:0] entry;
    int          busy_at;
    unmap = 1'($urandom_range(1));
    root  = 52'(random_word());
    if (root == '0) root = 52'h1000;
    virt = random_word();
    if (unmap) virt[11:0] = 12'h000;
    else virt[63:47] = '0;
    queue_item(unmap ? OP_UNMAP : OP_TRANSLATE, root, virt, random_word());
    busy_at = $urandom_range(9);
    for (int lvl = 3; lvl >= 0; lvl--) begin
      if (lvl == busy_at) begin
        queue_item($urandom_range(1) ? OP_UNMAP : OP_TRANSLATE, 52'(random_word()),
                   random_word(), random_word());
      end
      entry    = random_word();
      entry[0] = ($urandom_range(19) != 0);
      if (lvl == 1) entry[7] = ($urandom_range(9) == 0);
      queue_item(OP_MEM_RSP, 52'(random_word()), random_word(), entry);
    end
  endtask

  // Noise: the unused code, stray responses and requests with bad arguments.
  task automatic queue_noise();
    logic [51:0] root;
    logic [63:0] virt;
    root = ($urandom_range(2) == 0) ? '0 : 52'(random_word());
    virt = random_word();
    case ($urandom_range(3))
      0: queue_item(OP_UNUSED, 52'(random_word()), virt, random_word());
      1: queue_item(OP_MEM_RSP, 52'(random_word()), virt, random_word());
      2: begin
        virt[$urandom_range(63, 47)] = 1'b1;
        queue_item(OP_TRANSLATE, root, virt, random_word());
      end
      default: begin
        if (virt[11:0] == 12'h000) virt[0] = 1'b1;
        queue_item(OP_UNMAP, root, virt, random_word());
      end
    endcase
  endtask

  task automatic queue_random_items(int count);
    int goal;
    goal = items_queued + count;
    while (items_queued < goal) begin
      if ($urandom_range(4) != 0) queue_walk();
      else queue_noise();
    end
  endtask

  // Waits until every item has had its transfer and every owed result has
  // arrived, then lets the walker drain for items that cause no result. A walk
  // left open is closed with a not-present entry so that the walker is truly
  // idle before the next register write.
  task automatic wait_walker_idle();
    do begin
      while (items_accepted != items_queued || walker_answers.size() != 0) begin
        @(posedge clk_i);
      end
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (walking) queue_item(OP_MEM_RSP, '0, '0, '0);
    end while (items_accepted != items_queued);
  endtask

  // Reads mmio_flag_bit back and compares it with our copy.
  task automatic read_flag_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FLAG_REG_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("mmio_flag_bit", 64'({26'd0, mmio_flag_pos}), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes mmio_flag_bit: a setup cycle, then an access cycle that completes
  // the transfer while pready is high. The read-back starts its setup cycle
  // right after the access cycle. Only called with the walker idle.
  task automatic write_flag_reg(logic [5:0] pos);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLAG_REG_ADDR;
    pwdata  <= {26'd0, pos};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mmio_flag_pos = pos;
    read_flag_reg();
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_TRANSLATE;
    req_if.root_table = '0;
    req_if.virt_addr  = '0;
    req_if.entry_data = '0;
    rsp_if.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_flag_reg();

    // Directed part, at the reset value of mmio_flag_bit.
    // Bad arguments: zero root, a translate just above the user range and a
    // misaligned unmap. Then the unused code and a response with no walk.
    queue_item(OP_TRANSLATE, '0, 64'h0000_0000_0000_1000, '0);
    queue_item(OP_TRANSLATE, 52'h1000, 64'h0000_8000_0000_0000, '0);
    queue_item(OP_UNMAP, 52'h1000, 64'h0000_0000_0000_1801, '0);
    queue_item(OP_UNUSED, '1, '1, '1);
    queue_item(OP_MEM_RSP, '1, '1, '1);
    // The highest root and the top user address make the table address wrap.
    // All-ones entries pass the top levels and stop at level two as a large page.
    queue_item(OP_TRANSLATE, '1, USER_TOP, '0);
    queue_item(OP_MEM_RSP, '0, '0, '1);
    queue_item(OP_MEM_RSP, '0, '0, '1);
    queue_item(OP_MEM_RSP, '0, '0, '1);
    // Unmap of the highest aligned address. Both requests that arrive during
    // the walk are answered busy; the large bit at level three is ignored and
    // the leaf entry carries the MMIO flag.
    queue_item(OP_UNMAP, 52'h1000, 64'hFFFF_FFFF_FFFF_F000, '0);
    queue_item(OP_MEM_RSP, '0, '0, 64'h0000_0000_0000_2001);
    queue_item(OP_TRANSLATE, 52'h1000, '0, '0);
    queue_item(OP_UNMAP, 52'h1000, '0, '0);
    queue_item(OP_MEM_RSP, '0, '0, 64'hFFF0_0000_0000_0081);
    queue_item(OP_MEM_RSP, '0, '0, 64'h000F_FFFF_FFFF_F001);
    queue_item(OP_MEM_RSP, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
    // Translate through zero frames: only the page offset survives.
    queue_item(OP_TRANSLATE, 52'h8, 64'h0000_0000_0000_0FFF, '0);
    repeat (4) queue_item(OP_MEM_RSP, '0, '0, 64'h1);
    // Not present at the top level, then a response that finds no walk.
    queue_item(OP_TRANSLATE, 52'hF_FFFF_FFFF_F000, USER_TOP, '0);
    queue_item(OP_MEM_RSP, '0, '0, '0);
    queue_item(OP_MEM_RSP, '0, '0, 64'h1);

    // Random part, first with the receiver stalling most of the time.
    queue_random_items(680);
    wait_walker_idle();

    // Highest flag bit, with the sender idling most of the time.
    write_flag_reg(6'd63);
    send_idle_pct <= 71;
    rsp_idle_pct  <= 8;
    queue_random_items(680);
    wait_walker_idle();

    // Lowest flag bit at full rate, opening with the long receiver stall.
    write_flag_reg(6'd0);
    send_idle_pct <= 0;
    rsp_idle_pct  <= 0;
    queue_random_items(680);
    hold_go <= 1'b1;
    wait_walker_idle();

    // A last short stretch at some flag bit in between.
    write_flag_reg(6'($urandom_range(62, 1)));
    queue_random_items(100);
    wait_walker_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // A hung handshake or a result that never arrives ends here.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* four_level_page_table_walker.f */
sv/pgwalk_pkg.sv
sv/pgwalk_if.sv
sv/pgwalk_front.sv
sv/pgwalk_queue.sv
sv/pgwalk_back.sv
sv/four_level_page_table_walker.sv
tb/testbench.sv
